// ===== rtl/core/mawu_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average with warm-up: shared definitions
// Register layout and controller state encoding for the averaging unit.
// ----------------------------------------------------------------------------
package mawu_pkg;

	localparam int WIN_W = 7;
	localparam logic [WIN_W-1:0] WIN_RESET = 7'd16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} mawu_state_t;

endpackage

// ===== rtl/core/moving_average_with_warmup_unit.sv =====
// ----------------------------------------------------------------------------
// Moving average with warm-up
// Boxcar average over a ring of recent samples, with a serial divider.
// ----------------------------------------------------------------------------
// Each sample request yields one average, the truncated mean of the samples
// in the window; until the ring has wrapped once the mean is taken over the
// samples received so far. The ring lives in one memory that is read when a
// sample is taken and written back in the cycle after, and the running sum
// is kept in a register. The restoring divider produces one quotient bit per
// cycle; a new sample is taken while the previous average still waits in
// the output register. After reset the ring is cleared entry by entry, during
// which no sample is taken; the window register may be written at any idle
// time, and values of zero or above WINDOW_MAX act as one and WINDOW_MAX
// respectively.
module moving_average_with_warmup_unit #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   window_valid,
	output logic                   window_ready,
	input  logic [mawu_pkg::WIN_W-1:0] window_length,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   average_valid,
	input  logic                   average_ready,
	output logic [SAMPLE_BITS-1:0] average
);

	import mawu_pkg::*;

	localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = (POS_W + 1 > WIN_W) ? POS_W + 1 : WIN_W;
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int BIT_W = $clog2(SUM_W);
	localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(WINDOW_MAX);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_MAX - 1);
	localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_MAX * ((1 << SAMPLE_BITS) - 1));

	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];

	mawu_state_t state_q, state_d;

	logic [WIN_W-1:0]       win_q;
	logic [POS_W-1:0]       clr_cnt_q;
	logic [POS_W-1:0]       pos_q;
	logic                   filled_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] fresh_q;
	logic [SAMPLE_BITS-1:0] old_s1;
	logic [CNT_W-1:0]       dvsr_q;
	logic [CNT_W-1:0]       rem_q;
	logic [SUM_W-1:0]       div_q;
	logic [BIT_W-1:0]       bit_cnt_q;
	logic                   avg_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;

	logic                   mem_we;
	logic [POS_W-1:0]       mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic                   take;
	logic                   load_out;

	logic [CNT_W-1:0]       win_ext;
	logic [CNT_W-1:0]       len_eff;
	logic [CNT_W-1:0]       next_pos;
	logic                   wrap;
	logic [SUM_W-1:0]       sum_new;
	logic [CNT_W:0]         trial;
	logic [CNT_W:0]         trial_diff;
	logic                   trial_ge;
	logic [SAMPLE_BITS-1:0] quo_sat;

	assign window_ready  = 1'b1;
	assign average_valid = avg_valid_q;
	assign average       = avg_q;
	assign take          = sample_valid && sample_ready;

	always_comb begin
		win_ext = CNT_W'(win_q);
		priority if (win_ext == '0) begin
			len_eff = CNT_W'(1);
		end else if (win_ext > LEN_MAX) begin
			len_eff = LEN_MAX;
		end else begin
			len_eff = win_ext;
		end
		next_pos   = CNT_W'(pos_q) + CNT_W'(1);
		wrap       = (next_pos >= len_eff);
		sum_new    = sum_q - SUM_W'(old_s1) + SUM_W'(fresh_q);
		trial      = {rem_q, div_q[SUM_W-1]};
		trial_diff = trial - {1'b0, dvsr_q};
		trial_ge   = (trial >= {1'b0, dvsr_q});
		if (|div_q[SUM_W-1:SAMPLE_BITS]) begin
			quo_sat = '1;
		end else begin
			quo_sat = div_q[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == POS_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_DIV;
			ST_DIV: begin
				if (bit_cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!avg_valid_q || average_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = pos_q;
		mem_wdata    = fresh_q;
		load_out     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			ST_IDLE:  sample_ready = 1'b1;
			ST_READ:  mem_we = 1'b1;
			ST_DIV: begin
			end
			ST_DONE:  load_out = !avg_valid_q || average_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			old_s1 <= ring_mem[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			win_q       <= WIN_RESET;
			clr_cnt_q   <= '0;
			pos_q       <= '0;
			filled_q    <= 1'b0;
			sum_q       <= '0;
			bit_cnt_q   <= '0;
			avg_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (window_valid) begin
				win_q <= window_length;
			end
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + POS_W'(1);
			end
			if (state_q == ST_READ) begin
				sum_q     <= sum_new;
				bit_cnt_q <= BIT_W'(SUM_W - 1);
				if (wrap) begin
					pos_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					pos_q <= POS_W'(next_pos);
				end
			end else if (state_q == ST_DIV) begin
				bit_cnt_q <= bit_cnt_q - BIT_W'(1);
			end
			if (load_out) begin
				avg_valid_q <= 1'b1;
			end else if (average_ready) begin
				avg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fresh_q <= sample;
		end
		if (state_q == ST_READ) begin
			div_q <= sum_new;
			rem_q <= '0;
			if (wrap || filled_q) begin
				dvsr_q <= len_eff;
			end else begin
				dvsr_q <= next_pos;
			end
		end else if (state_q == ST_DIV) begin
			div_q <= {div_q[SUM_W-2:0], trial_ge};
			if (trial_ge) begin
				rem_q <= trial_diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
		if (load_out) begin
			avg_q <= quo_sat;
		end
	end

	a_pos_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < WINDOW_MAX)
		else $error("write position outside the ring");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("running sum exceeds the ring capacity");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvsr_q != '0))
		else $error("division by zero started");

	a_request_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == ST_READ) && !sample_ready)
		else $error("accepted request did not start a ring update");

	a_filled_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(filled_q) |-> filled_q)
		else $error("filled flag cleared while running");

endmodule
